// ===== hdl/fvpl_pkg.sv =====
package fvpl_pkg;

    localparam int MODE_W     = 2;
    localparam int DIST_W     = 13;
    localparam int STEP_W     = 10;
    localparam int ILIM_W     = 15;
    localparam int TLIM_W     = 8;
    localparam int GAIN_W     = 8;
    localparam int TILT_W     = 9;

    localparam int FILT_W     = 22;
    localparam int INTEG_W    = 24;
    localparam int SETP_W     = 20;
    localparam int DRIVE_W    = 22;

    localparam int FILT_MAX   = (1 << (FILT_W - 1)) - 1;
    localparam int INTEG_MAX  = (1 << (INTEG_W - 1)) - 1;
    localparam int SETP_MAX   = (1 << (SETP_W - 1)) - 1;
    localparam int DRIVE_MAX  = (1 << (DRIVE_W - 1)) - 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REMOTE_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd7;

    localparam logic [MODE_W-1:0] MODE_FOLLOW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOTE = 2'd2;

    // Filter: 205*f + 51*x is computed as 256*f + 51*(x - f).
    localparam int NEW_COEF   = 51;
    localparam int FILT_SHIFT = 8;
    localparam int FILT_ROUND = 128;

    // Division of the distance error by ten through a reciprocal.
    localparam int EMAG_W      = DIST_W + 1;
    localparam int QUOT_W      = 11;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP = 16'hCCCD;

    localparam int NSTAGE  = 7;
    localparam int ST_IN   = 0;
    localparam int ST_PRE  = 1;
    localparam int ST_DIV  = 2;
    localparam int ST_FILT = 3;
    localparam int ST_INT  = 4;
    localparam int ST_PROD = 5;
    localparam int ST_OUT  = 6;

    typedef struct packed {
        logic [MODE_W-1:0] op_mode;
        logic [DIST_W-1:0] target_distance_mm;
        logic [DIST_W-1:0] far_limit_mm;
        logic [STEP_W-1:0] remote_step;
        logic [ILIM_W-1:0] integral_limit;
        logic [TLIM_W-1:0] tilt_limit_deg;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i_q8;
    } cfg_t;

    typedef struct packed {
        logic same_sign;
        logic far;
        logic neg;
        logic tilt_over;
    } sp_flags_t;

    typedef struct packed {
        logic [NSTAGE-1:0] ld;
        logic [NSTAGE-1:0] vld;
    } pipe_ctl_t;

endpackage

// ===== hdl/follow_velocity_pi_loop.sv =====
// An accepted beat passes the input, prep, divide, filter, integrator and product registers
// to the output on m_drive. Throughput: one beat per cycle while the output is not stalled.
// A stalled result holds the output register while free pipeline stages keep accepting.
// Reset clears the filtered speed, integral and setpoint to zero, empties the pipeline
// and loads the configuration registers with their default values.
module follow_velocity_pi_loop #(
    parameter int FRAC_BITS  = 8,
    parameter int COUNT_BITS = 12
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [fvpl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fvpl_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [COUNT_BITS-1:0]           s_left_count,
    input  logic signed [COUNT_BITS-1:0]           s_right_count,
    input  logic [fvpl_pkg::DIST_W-1:0]            s_dist_left_mm,
    input  logic [fvpl_pkg::DIST_W-1:0]            s_dist_right_mm,
    input  logic signed [fvpl_pkg::TILT_W-1:0]     s_tilt_deg,
    input  logic                                   s_go_forward,
    input  logic                                   s_go_back,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [fvpl_pkg::DRIVE_W-1:0]    m_drive
);
    import fvpl_pkg::*;

    localparam cfg_t CFG_RESET = '{
        op_mode:            MODE_FOLLOW,
        target_distance_mm: 13'd600,
        far_limit_mm:       13'd2000,
        remote_step:        10'd60,
        integral_limit:     15'd10000,
        tilt_limit_deg:     8'd50,
        gain_p:             8'd80,
        gain_i_q8:          8'd102
    };

    cfg_t                         cfg_reg;
    cfg_t                         cfg_next;
    logic [NSTAGE-1:0]            vld_reg;
    logic [NSTAGE-1:0]            vld_next;
    logic [NSTAGE-1:0]            ld;
    pipe_ctl_t                    ctl;

    logic signed [COUNT_BITS-1:0] cl_reg;
    logic signed [COUNT_BITS-1:0] cr_reg;
    logic [DIST_W-1:0]            dl_reg;
    logic [DIST_W-1:0]            dr_reg;
    logic signed [TILT_W-1:0]     tilt_reg;
    logic                         fwd_reg;
    logic                         back_reg;

    logic [QUOT_W-1:0]            quot;
    logic [EMAG_W-1:0]            emag;
    sp_flags_t                    flags;
    logic signed [SETP_W-1:0]     remote_sp;
    logic signed [COUNT_BITS:0]   count_sum;
    logic signed [FILT_W-1:0]     filt;
    logic signed [INTEG_W-1:0]    integ;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_OP_MODE:     cfg_next.op_mode            = cfg_wdata[MODE_W-1:0];
                REG_TARGET_DIST: cfg_next.target_distance_mm = cfg_wdata[DIST_W-1:0];
                REG_FAR_LIMIT:   cfg_next.far_limit_mm       = cfg_wdata[DIST_W-1:0];
                REG_REMOTE_STEP: cfg_next.remote_step        = cfg_wdata[STEP_W-1:0];
                REG_INTEG_LIMIT: cfg_next.integral_limit     = cfg_wdata[ILIM_W-1:0];
                REG_TILT_LIMIT:  cfg_next.tilt_limit_deg     = cfg_wdata[TLIM_W-1:0];
                REG_GAIN_P:      cfg_next.gain_p             = cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:      cfg_next.gain_i_q8          = cfg_wdata[GAIN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // A stage loads when it is empty or when its beat moves on.
    always_comb begin
        ld[ST_OUT] = !vld_reg[ST_OUT] || m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
        vld_next[ST_IN] = ld[ST_IN] ? s_valid : vld_reg[ST_IN];
        for (int k = 1; k < NSTAGE; k++) begin
            vld_next[k] = ld[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign ctl.ld  = ld;
    assign ctl.vld = vld_reg;
    assign s_ready = ld[ST_IN];
    assign m_valid = vld_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (ld[ST_IN]) begin
            cl_reg   <= s_left_count;
            cr_reg   <= s_right_count;
            dl_reg   <= s_dist_left_mm;
            dr_reg   <= s_dist_right_mm;
            tilt_reg <= s_tilt_deg;
            fwd_reg  <= s_go_forward;
            back_reg <= s_go_back;
        end
    end

    fvpl_prep #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_prep (
        .aclk          (aclk),
        .ctl           (ctl),
        .cfg           (cfg_reg),
        .left_count    (cl_reg),
        .right_count   (cr_reg),
        .dist_left_mm  (dl_reg),
        .dist_right_mm (dr_reg),
        .tilt_deg      (tilt_reg),
        .go_forward    (fwd_reg),
        .go_back       (back_reg),
        .quot          (quot),
        .emag          (emag),
        .flags         (flags),
        .remote_sp     (remote_sp),
        .count_sum     (count_sum)
    );

    fvpl_state #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .cfg       (cfg_reg),
        .quot      (quot),
        .emag      (emag),
        .flags     (flags),
        .remote_sp (remote_sp),
        .count_sum (count_sum),
        .filt      (filt),
        .integ     (integ)
    );

    fvpl_gain #(
        .FRAC_BITS (FRAC_BITS)
    ) u_gain (
        .aclk  (aclk),
        .ctl   (ctl),
        .cfg   (cfg_reg),
        .filt  (filt),
        .integ (integ),
        .drive (m_drive)
    );

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("Input stalled while the output register is empty.");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[ST_IN])
        else $error("Accepted beat not held in the input register.");

endmodule

// ===== hdl/fvpl_prep.sv =====
module fvpl_prep #(
    parameter int FRAC_BITS  = 8,
    parameter int COUNT_BITS = 12
) (
    input  logic                                   aclk,
    input  fvpl_pkg::pipe_ctl_t                    ctl,
    input  fvpl_pkg::cfg_t                         cfg,
    input  logic signed [COUNT_BITS-1:0]           left_count,
    input  logic signed [COUNT_BITS-1:0]           right_count,
    input  logic [fvpl_pkg::DIST_W-1:0]            dist_left_mm,
    input  logic [fvpl_pkg::DIST_W-1:0]            dist_right_mm,
    input  logic signed [fvpl_pkg::TILT_W-1:0]     tilt_deg,
    input  logic                                   go_forward,
    input  logic                                   go_back,
    output logic [fvpl_pkg::QUOT_W-1:0]            quot,
    output logic [fvpl_pkg::EMAG_W-1:0]            emag,
    output fvpl_pkg::sp_flags_t                    flags,
    output logic signed [fvpl_pkg::SETP_W-1:0]     remote_sp,
    output logic signed [COUNT_BITS:0]             count_sum
);
    import fvpl_pkg::*;

    localparam int RS_W = STEP_W + FRAC_BITS;

    logic signed [DIST_W:0]   err_l;
    logic signed [DIST_W:0]   err_r;
    logic [DIST_W+1:0]        err_sum;
    logic [DIST_W+1:0]        err_abs;
    logic [TILT_W-1:0]        tilt_abs;
    logic [RS_W-1:0]          step_sh;
    logic signed [31:0]       step_s;
    logic signed [31:0]       remote_val;
    logic signed [COUNT_BITS:0] sum_now;
    sp_flags_t                flags_now;

    logic [EMAG_W-1:0]           emag1_reg;
    sp_flags_t                   flags1_reg;
    logic signed [SETP_W-1:0]    remote1_reg;
    logic signed [COUNT_BITS:0]  sum1_reg;

    logic [EMAG_W+RECIP_W-1:0]   prod;
    logic [QUOT_W-1:0]           quot2_reg;
    logic [EMAG_W-1:0]           emag2_reg;
    sp_flags_t                   flags2_reg;
    logic signed [SETP_W-1:0]    remote2_reg;
    logic signed [COUNT_BITS:0]  sum2_reg;

    always_comb begin
        err_l   = $signed({1'b0, dist_left_mm}) - $signed({1'b0, cfg.target_distance_mm});
        err_r   = $signed({1'b0, dist_right_mm}) - $signed({1'b0, cfg.target_distance_mm});
        err_sum = {err_l[DIST_W], err_l} + {err_r[DIST_W], err_r};
        err_abs = err_sum[DIST_W+1] ? (~err_sum + 1'b1) : err_sum;

        flags_now.same_sign = (!err_l[DIST_W] && (err_l != '0) &&
                               !err_r[DIST_W] && (err_r != '0)) ||
                              (err_l[DIST_W] && err_r[DIST_W]);
        flags_now.far = (dist_left_mm > cfg.far_limit_mm) ||
                        (dist_right_mm > cfg.far_limit_mm);
        flags_now.neg = err_sum[DIST_W+1];

        tilt_abs = tilt_deg[TILT_W-1] ? (~tilt_deg + 1'b1) : tilt_deg;
        flags_now.tilt_over = tilt_abs > {1'b0, cfg.tilt_limit_deg};

        step_sh = {cfg.remote_step, {FRAC_BITS{1'b0}}};
        step_s  = $signed(32'(step_sh));
        if (go_forward) begin
            remote_val = (step_s > SETP_MAX) ? SETP_MAX : step_s;
        end else if (go_back) begin
            remote_val = (step_s > SETP_MAX + 1) ? -(SETP_MAX + 1) : -step_s;
        end else begin
            remote_val = '0;
        end

        sum_now = (COUNT_BITS+1)'(left_count) + (COUNT_BITS+1)'(right_count);
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[ST_PRE]) begin
            emag1_reg   <= err_abs[EMAG_W-1:0];
            flags1_reg  <= flags_now;
            remote1_reg <= SETP_W'(remote_val);
            sum1_reg    <= sum_now;
        end
    end

    assign prod = emag1_reg * RECIP;

    always_ff @(posedge aclk) begin
        if (ctl.ld[ST_DIV]) begin
            quot2_reg   <= prod[RECIP_SHIFT +: QUOT_W];
            emag2_reg   <= emag1_reg;
            flags2_reg  <= flags1_reg;
            remote2_reg <= remote1_reg;
            sum2_reg    <= sum1_reg;
        end
    end

    assign quot      = quot2_reg;
    assign emag      = emag2_reg;
    assign flags     = flags2_reg;
    assign remote_sp = remote2_reg;
    assign count_sum = sum2_reg;

endmodule

// ===== hdl/fvpl_state.sv =====
module fvpl_state #(
    parameter int FRAC_BITS  = 8,
    parameter int COUNT_BITS = 12
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  fvpl_pkg::pipe_ctl_t                    ctl,
    input  fvpl_pkg::cfg_t                         cfg,
    input  logic [fvpl_pkg::QUOT_W-1:0]            quot,
    input  logic [fvpl_pkg::EMAG_W-1:0]            emag,
    input  fvpl_pkg::sp_flags_t                    flags,
    input  logic signed [fvpl_pkg::SETP_W-1:0]     remote_sp,
    input  logic signed [COUNT_BITS:0]             count_sum,
    output logic signed [fvpl_pkg::FILT_W-1:0]     filt,
    output logic signed [fvpl_pkg::INTEG_W-1:0]    integ
);
    import fvpl_pkg::*;

    localparam int SH_W  = COUNT_BITS + 1 + FRAC_BITS;
    localparam int DIF_W = ((SH_W > FILT_W) ? SH_W : FILT_W) + 1;
    localparam int ACC_W = ((DIF_W + 6 > FILT_W + FILT_SHIFT) ?
                            DIF_W + 6 : FILT_W + FILT_SHIFT) + 2;
    localparam int IA_W  = ((INTEG_W + 2 > ILIM_W + FRAC_BITS + 1) ?
                            INTEG_W + 2 : ILIM_W + FRAC_BITS + 1) + 1;

    logic [EMAG_W-1:0]           rem_full;
    logic [3:0]                  rem_dig;
    logic [FRAC_BITS-1:0]        frac;
    logic [QUOT_W+FRAC_BITS-1:0] fmag;
    logic signed [31:0]          fmag_s;
    logic signed [31:0]          follow_val;

    logic signed [SH_W-1:0]      sum_sh;
    logic signed [DIF_W-1:0]     dif;
    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-1:0]     acc_sh;
    logic signed [FILT_W-1:0]    filt_sat;

    logic signed [IA_W-1:0]      lim_s;
    logic signed [IA_W-1:0]      int_sum;
    logic signed [IA_W-1:0]      int_clamp;
    logic signed [INTEG_W-1:0]   int_sat;
    logic signed [INTEG_W-1:0]   integ_prev;
    logic                        upd_sp;

    logic signed [SETP_W-1:0]    setpoint_reg;
    logic signed [SETP_W-1:0]    setpoint_next;
    logic signed [FILT_W-1:0]    filtered_reg;
    logic signed [FILT_W-1:0]    filtered_next;
    logic                        tover3_reg;

    logic signed [FILT_W-1:0]    filt4_reg;
    logic signed [INTEG_W-1:0]   integ4_reg;
    logic                        tover4_reg;

    always_comb begin
        rem_full = emag - ((EMAG_W'(quot) << 3) + (EMAG_W'(quot) << 1));
        rem_dig  = rem_full[3:0];
        case (rem_dig)
            4'd0:    frac = '0;
            4'd1:    frac = FRAC_BITS'((64'd1 << FRAC_BITS) / 10);
            4'd2:    frac = FRAC_BITS'((64'd2 << FRAC_BITS) / 10);
            4'd3:    frac = FRAC_BITS'((64'd3 << FRAC_BITS) / 10);
            4'd4:    frac = FRAC_BITS'((64'd4 << FRAC_BITS) / 10);
            4'd5:    frac = FRAC_BITS'((64'd5 << FRAC_BITS) / 10);
            4'd6:    frac = FRAC_BITS'((64'd6 << FRAC_BITS) / 10);
            4'd7:    frac = FRAC_BITS'((64'd7 << FRAC_BITS) / 10);
            4'd8:    frac = FRAC_BITS'((64'd8 << FRAC_BITS) / 10);
            4'd9:    frac = FRAC_BITS'((64'd9 << FRAC_BITS) / 10);
            default: frac = '0;
        endcase
        fmag   = {quot, frac};
        fmag_s = $signed(32'(fmag));
        if (flags.neg) begin
            follow_val = (fmag_s > SETP_MAX + 1) ? -(SETP_MAX + 1) : -fmag_s;
        end else begin
            follow_val = (fmag_s > SETP_MAX) ? SETP_MAX : fmag_s;
        end
    end

    assign upd_sp = ctl.ld[ST_FILT] && ctl.vld[ST_DIV];

    always_comb begin
        setpoint_next = setpoint_reg;
        if (upd_sp) begin
            case (cfg.op_mode)
                MODE_FOLLOW: begin
                    if (flags.far) begin
                        setpoint_next = '0;
                    end else if (flags.same_sign) begin
                        setpoint_next = SETP_W'(follow_val);
                    end
                end
                MODE_REMOTE: setpoint_next = remote_sp;
                default:     setpoint_next = setpoint_reg;
            endcase
        end
    end

    always_comb begin
        sum_sh = {count_sum, {FRAC_BITS{1'b0}}};
        dif    = DIF_W'(sum_sh) - DIF_W'(filtered_reg);
        acc    = (ACC_W'(filtered_reg) <<< FILT_SHIFT) + ACC_W'(dif) * ACC_W'(NEW_COEF)
                 + ACC_W'(FILT_ROUND);
        acc_sh = acc >>> FILT_SHIFT;
        if (acc_sh > ACC_W'(FILT_MAX)) begin
            filt_sat = FILT_W'(FILT_MAX);
        end else if (acc_sh < ACC_W'(-FILT_MAX - 1)) begin
            filt_sat = FILT_W'(-FILT_MAX - 1);
        end else begin
            filt_sat = FILT_W'(acc_sh);
        end
        filtered_next = upd_sp ? filt_sat : filtered_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= '0;
            filtered_reg <= '0;
        end else begin
            setpoint_reg <= setpoint_next;
            filtered_reg <= filtered_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[ST_FILT]) begin
            tover3_reg <= flags.tilt_over;
        end
    end

    always_comb begin
        integ_prev = tover4_reg ? '0 : integ4_reg;
        lim_s = $signed({{(IA_W-ILIM_W-FRAC_BITS){1'b0}}, cfg.integral_limit,
                         {FRAC_BITS{1'b0}}});
        int_sum = IA_W'(integ_prev) + IA_W'(filtered_reg) - IA_W'(setpoint_reg);
        if (int_sum > lim_s) begin
            int_clamp = lim_s;
        end else if (int_sum < -lim_s) begin
            int_clamp = -lim_s;
        end else begin
            int_clamp = int_sum;
        end
        if (int_clamp > IA_W'(INTEG_MAX)) begin
            int_sat = INTEG_W'(INTEG_MAX);
        end else if (int_clamp < IA_W'(-INTEG_MAX - 1)) begin
            int_sat = INTEG_W'(-INTEG_MAX - 1);
        end else begin
            int_sat = INTEG_W'(int_clamp);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ4_reg <= '0;
            tover4_reg <= 1'b0;
        end else if (ctl.ld[ST_INT] && ctl.vld[ST_FILT]) begin
            integ4_reg <= int_sat;
            tover4_reg <= tover3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[ST_INT]) begin
            filt4_reg <= filtered_reg;
        end
    end

    assign filt  = filt4_reg;
    assign integ = integ4_reg;

    a_far_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_sp && (cfg.op_mode == MODE_FOLLOW) && flags.far |=> setpoint_reg == '0)
        else $error("Follow setpoint not zeroed beyond the far limit.");

    a_integ_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.vld[ST_INT] |-> (IA_W'(integ4_reg) <= lim_s) && (IA_W'(integ4_reg) >= -lim_s))
        else $error("Integral outside the configured clamp.");

endmodule

// ===== hdl/fvpl_gain.sv =====
module fvpl_gain #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                   aclk,
    input  fvpl_pkg::pipe_ctl_t                    ctl,
    input  fvpl_pkg::cfg_t                         cfg,
    input  logic signed [fvpl_pkg::FILT_W-1:0]     filt,
    input  logic signed [fvpl_pkg::INTEG_W-1:0]    integ,
    output logic signed [fvpl_pkg::DRIVE_W-1:0]    drive
);
    import fvpl_pkg::*;

    localparam int PP_W  = GAIN_W + 1 + FILT_W;
    localparam int IP_W  = GAIN_W + 1 + INTEG_W;
    localparam int NUM_W = PP_W + 9;
    localparam int DSH   = FRAC_BITS + 8;

    logic signed [PP_W-1:0]    pp_now;
    logic signed [IP_W-1:0]    ip_now;
    logic signed [PP_W-1:0]    pp_reg;
    logic signed [IP_W-1:0]    ip_reg;
    logic signed [NUM_W-1:0]   num;
    logic signed [NUM_W-1:0]   bias;
    logic signed [NUM_W-1:0]   quo;
    logic signed [DRIVE_W-1:0] drive_next;
    logic signed [DRIVE_W-1:0] drive_reg;

    assign pp_now = $signed({1'b0, cfg.gain_p}) * filt;
    assign ip_now = $signed({1'b0, cfg.gain_i_q8}) * integ;

    always_ff @(posedge aclk) begin
        if (ctl.ld[ST_PROD]) begin
            pp_reg <= pp_now;
            ip_reg <= ip_now;
        end
    end

    // Division by a power of two, rounded toward zero.
    always_comb begin
        num  = (NUM_W'(pp_reg) <<< 8) + NUM_W'(ip_reg);
        bias = num[NUM_W-1] ? $signed({{(NUM_W-DSH){1'b0}}, {DSH{1'b1}}}) : '0;
        quo  = (num + bias) >>> DSH;
        if (quo > NUM_W'(DRIVE_MAX)) begin
            drive_next = DRIVE_W'(DRIVE_MAX);
        end else if (quo < NUM_W'(-DRIVE_MAX - 1)) begin
            drive_next = DRIVE_W'(-DRIVE_MAX - 1);
        end else begin
            drive_next = DRIVE_W'(quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld[ST_OUT]) begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fvpl_pkg::*;

    localparam int FRAC         = 8;
    localparam int CNT_W        = 12;
    localparam int KEEP_WEIGHT  = 205;
    localparam int NEW_WEIGHT   = 51;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_TICKS  = 41;

    typedef struct {
        logic signed [CNT_W-1:0]  left_count;
        logic signed [CNT_W-1:0]  right_count;
        logic [DIST_W-1:0]        dist_left_mm;
        logic [DIST_W-1:0]        dist_right_mm;
        logic signed [TILT_W-1:0] tilt_deg;
        logic                     go_forward;
        logic                     go_back;
    } tick_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [CNT_W-1:0]  s_left_count = '0;
    logic signed [CNT_W-1:0]  s_right_count = '0;
    logic [DIST_W-1:0]        s_dist_left_mm = '0;
    logic [DIST_W-1:0]        s_dist_right_mm = '0;
    logic signed [TILT_W-1:0] s_tilt_deg = '0;
    logic                     s_go_forward = 1'b0;
    logic                     s_go_back = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DRIVE_W-1:0] m_drive;

    tick_t                     ticks_pending[$];
    logic signed [DRIVE_W-1:0] drive_expected[$];

    cfg_t   loop_cfg;
    longint filt_speed;
    longint speed_sum;
    longint move_setpoint;

    logic s_fire = 1'b0;
    int   mismatches = 0;
    int   results_seen = 0;
    int   cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   pattern_left = 0;
    int   stall_pct = 0;

    follow_velocity_pi_loop #(
        .FRAC_BITS (FRAC),
        .COUNT_BITS(CNT_W)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_count   (s_left_count),
        .s_right_count  (s_right_count),
        .s_dist_left_mm (s_dist_left_mm),
        .s_dist_right_mm(s_dist_right_mm),
        .s_tilt_deg     (s_tilt_deg),
        .s_go_forward   (s_go_forward),
        .s_go_back      (s_go_back),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive        (m_drive)
    );

    always #5 aclk = ~aclk;

    function automatic longint clamp_bits(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic signed [DRIVE_W-1:0] next_drive(tick_t t);
        longint cl, cr, dl, dr, tilt, el, er, target, far, step;
        longint acc, lim, gp, gi, num, drv;
        cl = t.left_count;
        cr = t.right_count;
        dl = t.dist_left_mm;
        dr = t.dist_right_mm;
        tilt = t.tilt_deg;
        target = loop_cfg.target_distance_mm;
        far = loop_cfg.far_limit_mm;
        step = loop_cfg.remote_step;
        gp = loop_cfg.gain_p;
        gi = loop_cfg.gain_i_q8;
        lim = longint'(loop_cfg.integral_limit) <<< FRAC;

        if (loop_cfg.op_mode == MODE_FOLLOW) begin
            el = dl - target;
            er = dr - target;
            if ((el > 0 && er > 0) || (el < 0 && er < 0)) begin
                move_setpoint = clamp_bits(((el + er) <<< FRAC) / 10, SETP_W);
            end
            if (dl > far || dr > far) begin
                move_setpoint = 0;
            end
        end else if (loop_cfg.op_mode == MODE_REMOTE) begin
            if (t.go_forward) begin
                move_setpoint = step <<< FRAC;
            end else if (t.go_back) begin
                move_setpoint = -(step <<< FRAC);
            end else begin
                move_setpoint = 0;
            end
            move_setpoint = clamp_bits(move_setpoint, SETP_W);
        end

        acc = KEEP_WEIGHT * filt_speed + NEW_WEIGHT * ((cl + cr) <<< FRAC) + 128;
        filt_speed = clamp_bits(acc >>> 8, FILT_W);

        acc = speed_sum + filt_speed - move_setpoint;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        speed_sum = clamp_bits(acc, INTEG_W);

        num = gp * filt_speed * 256 + gi * speed_sum;
        drv = clamp_bits(num / (longint'(1) <<< (FRAC + 8)), DRIVE_W);

        if (tilt < 0) tilt = -tilt;
        if (tilt > longint'(loop_cfg.tilt_limit_deg)) begin
            speed_sum = 0;
        end
        return drv[DRIVE_W-1:0];
    endfunction

    function automatic tick_t make_tick(int l, int r, int dl, int dr, int tilt, bit f, bit b);
        tick_t t;
        t.left_count = CNT_W'(l);
        t.right_count = CNT_W'(r);
        t.dist_left_mm = DIST_W'(dl);
        t.dist_right_mm = DIST_W'(dr);
        t.tilt_deg = TILT_W'(tilt);
        t.go_forward = f;
        t.go_back = b;
        return t;
    endfunction

    function automatic int clip_dist(int d);
        if (d < 0) return 0;
        if (d > 8191) return 8191;
        return d;
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int target, far, tl, sgn, d0, d1, tilt;
        target = loop_cfg.target_distance_mm;
        far = loop_cfg.far_limit_mm;
        tl = loop_cfg.tilt_limit_deg;
        case ($urandom_range(0, 9))
            0: begin
                d0 = $urandom_range(0, 8191);
                d1 = $urandom_range(0, 8191);
            end
            1: begin
                d0 = far + int'($urandom_range(1, 400));
                d1 = $urandom_range(0, 8191);
            end
            default: begin
                sgn = ($urandom_range(0, 1) == 1) ? 1 : -1;
                d0 = target + sgn * int'($urandom_range(0, 500));
                if ($urandom_range(0, 3) == 0) sgn = -sgn;
                d1 = target + sgn * int'($urandom_range(0, 500));
            end
        endcase
        case ($urandom_range(0, 7))
            0: tilt = $urandom_range(0, 511) - 256;
            1: tilt = (($urandom_range(0, 1) == 1) ? 1 : -1) * (tl + int'($urandom_range(0, 3)));
            default: tilt = int'($urandom_range(0, 2 * tl)) - tl;
        endcase
        if (tilt > 255) tilt = 255;
        if (tilt < -256) tilt = -256;
        if ($urandom_range(0, 7) == 0) begin
            t = make_tick($urandom, $urandom, clip_dist(d0), clip_dist(d1), tilt,
                          $urandom_range(0, 1), $urandom_range(0, 1));
        end else begin
            t = make_tick(int'($urandom_range(0, 160)) - 80, int'($urandom_range(0, 160)) - 80,
                          clip_dist(d0), clip_dist(d1), tilt,
                          $urandom_range(0, 1), $urandom_range(0, 1));
        end
        return t;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (ticks_pending.size() != 0 || s_valid || drive_expected.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic program_random();
        int mode, target, far, pick;
        pick = $urandom_range(0, 9);
        mode = (pick < 4) ? MODE_FOLLOW : (pick < 7) ? MODE_REMOTE : (pick == 8) ? 0 : 3;
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(200, 1500);
        far = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191)
                                          : clip_dist(target + int'($urandom_range(200, 3000)));
        write_reg(REG_OP_MODE, ($urandom & 32'h7FFC) | mode);
        write_reg(REG_TARGET_DIST, target);
        write_reg(REG_FAR_LIMIT, far);
        write_reg(REG_REMOTE_STEP, $urandom_range(0, 1023));
        write_reg(REG_INTEG_LIMIT, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32767)
                                                               : $urandom_range(0, 2000));
        write_reg(REG_TILT_LIMIT, ($urandom & 32'h7F00) |
                                  (($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 180)));
        write_reg(REG_GAIN_P, $urandom_range(0, 255));
        write_reg(REG_GAIN_I, $urandom_range(0, 255));
    endtask

    // Input side: accepted beats feed the predictor, config writes update its copy.
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        if (!aresetn) begin
            loop_cfg = '{op_mode: MODE_FOLLOW, target_distance_mm: 600, far_limit_mm: 2000,
                         remote_step: 60, integral_limit: 10000, tilt_limit_deg: 50,
                         gain_p: 80, gain_i_q8: 102};
            filt_speed = 0;
            speed_sum = 0;
            move_setpoint = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_OP_MODE:     loop_cfg.op_mode = cfg_wdata[MODE_W-1:0];
                    REG_TARGET_DIST: loop_cfg.target_distance_mm = cfg_wdata[DIST_W-1:0];
                    REG_FAR_LIMIT:   loop_cfg.far_limit_mm = cfg_wdata[DIST_W-1:0];
                    REG_REMOTE_STEP: loop_cfg.remote_step = cfg_wdata[STEP_W-1:0];
                    REG_INTEG_LIMIT: loop_cfg.integral_limit = cfg_wdata[ILIM_W-1:0];
                    REG_TILT_LIMIT:  loop_cfg.tilt_limit_deg = cfg_wdata[TLIM_W-1:0];
                    REG_GAIN_P:      loop_cfg.gain_p = cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_I:      loop_cfg.gain_i_q8 = cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                drive_expected.push_back(next_drive('{s_left_count, s_right_count,
                    s_dist_left_mm, s_dist_right_mm, s_tilt_deg, s_go_forward, s_go_back}));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (drive_expected.size() == 0) begin
                $display("%0t drive beat with none expected: expected none actual %0d",
                         $time, m_drive);
                mismatches++;
            end else if (m_drive !== drive_expected[0]) begin
                $display("%0t drive mismatch: expected %0d actual %0d",
                         $time, drive_expected[0], m_drive);
                mismatches++;
                void'(drive_expected.pop_front());
            end else begin
                void'(drive_expected.pop_front());
            end
        end
    end

    always @(negedge aclk) begin
        tick_t t;
        if (aresetn && (!s_valid || s_fire)) begin
            if (gap_left > 0 || ticks_pending.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_valid <= 1'b0;
            end else begin
                t = ticks_pending.pop_front();
                s_left_count <= t.left_count;
                s_right_count <= t.right_count;
                s_dist_left_mm <= t.dist_left_mm;
                s_dist_right_mm <= t.dist_right_mm;
                s_tilt_deg <= t.tilt_deg;
                s_go_forward <= t.go_forward;
                s_go_back <= t.go_back;
                s_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen > 80 && ticks_pending.size() > 30) begin
                hold_done = 1'b1;
                hold_left = 400;
                m_ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern_left = $urandom_range(16, 96);
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 30;
                        3: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end else begin
                    pattern_left--;
                end
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Follow mode at reset defaults: sign agreement, hold, far limit and tilt edges.
        ticks_pending.push_back(make_tick(0, 0, 0, 0, 0, 0, 0));
        ticks_pending.push_back(make_tick(2047, 2047, 600, 600, 0, 0, 0));
        ticks_pending.push_back(make_tick(2047, 2047, 700, 500, 10, 0, 0));
        ticks_pending.push_back(make_tick(2047, 2047, 900, 1000, -10, 1, 1));
        ticks_pending.push_back(make_tick(-2048, -2048, 2001, 800, 50, 0, 0));
        ticks_pending.push_back(make_tick(-2048, -2048, 8191, 8191, 51, 0, 0));
        ticks_pending.push_back(make_tick(-2048, 2047, 650, 620, -50, 0, 0));
        ticks_pending.push_back(make_tick(100, -100, 400, 300, -51, 0, 0));
        ticks_pending.push_back(make_tick(5, 5, 1000, 1000, 180, 0, 0));
        ticks_pending.push_back(make_tick(-5, -5, 1000, 1000, -180, 0, 0));
        ticks_pending.push_back(make_tick(0, 0, 1000, 1000, 255, 0, 0));
        ticks_pending.push_back(make_tick(0, 0, 1000, 1000, -256, 0, 0));
        ticks_pending.push_back(make_tick(-1, 1, 2000, 2000, 0, 0, 0));
        wait_idle();

        write_reg(REG_OP_MODE, MODE_REMOTE);
        ticks_pending.push_back(make_tick(30, 30, 100, 100, 0, 0, 0));
        ticks_pending.push_back(make_tick(30, 30, 100, 100, 0, 1, 1));
        ticks_pending.push_back(make_tick(-30, -30, 100, 100, 0, 0, 1));
        ticks_pending.push_back(make_tick(-30, -30, 100, 100, 0, 1, 0));
        wait_idle();

        // Unused modes must keep the setpoint left by the remote phase.
        write_reg(REG_OP_MODE, 0);
        ticks_pending.push_back(make_tick(10, 10, 900, 900, 0, 0, 1));
        ticks_pending.push_back(make_tick(10, 10, 300, 300, 0, 1, 0));
        wait_idle();
        write_reg(REG_OP_MODE, 3);
        ticks_pending.push_back(make_tick(-10, 10, 900, 900, 0, 0, 1));
        ticks_pending.push_back(make_tick(-10, 10, 300, 300, 0, 1, 0));
        wait_idle();

        write_reg(REG_OP_MODE, MODE_FOLLOW);
        write_reg(REG_TARGET_DIST, 8191);
        write_reg(REG_FAR_LIMIT, 8191);
        write_reg(REG_REMOTE_STEP, 1023);
        write_reg(REG_INTEG_LIMIT, 32767);
        write_reg(REG_TILT_LIMIT, 255);
        write_reg(REG_GAIN_P, 255);
        write_reg(REG_GAIN_I, 255);
        repeat (6) ticks_pending.push_back(make_tick(2047, 2047, 0, 0, 0, 0, 0));
        repeat (6) ticks_pending.push_back(make_tick(-2048, -2048, 8191, 0, 255, 0, 0));
        wait_idle();

        write_reg(REG_OP_MODE, MODE_REMOTE);
        write_reg(REG_TARGET_DIST, 0);
        write_reg(REG_FAR_LIMIT, 0);
        write_reg(REG_REMOTE_STEP, 0);
        write_reg(REG_INTEG_LIMIT, 0);
        write_reg(REG_TILT_LIMIT, 0);
        write_reg(REG_GAIN_P, 0);
        write_reg(REG_GAIN_I, 0);
        repeat (4) ticks_pending.push_back(make_tick(2047, -2048, 0, 8191, 1, 1, 0));
        wait_idle();
        write_reg(REG_GAIN_P, 255);
        write_reg(REG_GAIN_I, 255);
        wait_idle();
        repeat (4) ticks_pending.push_back(make_tick(2047, 2047, 0, 0, 0, 0, 1));
        wait_idle();

        repeat (RANDOM_PHASES) begin
            program_random();
            repeat (PHASE_TICKS) ticks_pending.push_back(random_tick());
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && drive_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
